// ===== rtl/rounded_euclidean_distance_macros.svh =====
// ----------------------------------------------------------------------------
// Rounded Euclidean distance assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_EUCLIDEAN_DISTANCE_MACROS_SVH
`define ROUNDED_EUCLIDEAN_DISTANCE_MACROS_SVH

// Check that cons holds whenever ante holds, outside reset.
`define RED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("red assertion failed");

// Check that cond holds at every edge outside reset.
`define RED_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("red assertion failed");

`endif

// ===== rtl/red_pkg.sv =====
// ----------------------------------------------------------------------------
// red_pkg
// Shared constants of the rounded Euclidean distance block.
// ----------------------------------------------------------------------------
package red_pkg;

  // Default coordinate width
  localparam int unsigned COORD_BITS_DEF = 16;

  // Width of the distance result
  localparam int unsigned DIST_BITS = 17;

endpackage

// ===== rtl/rounded_euclidean_distance.sv =====
// Pipeline of COORD_BITS+5 register stages (21 at COORD_BITS = 16): three front-end
// stages, one root cell per root bit and one rounding stage. Throughput: one request
// per cycle; busy_o stays low.
// The root chain of COORD_BITS+1 cells, one root bit each, sets the latency.
// Reset clears every valid bit at once; requests in flight are dropped.
// ----------------------------------------------------------------------------
// rounded_euclidean_distance
// Rounded Euclidean distance of two points with unsigned coordinates,
// pipelined through a chain of square-root cells.
// ----------------------------------------------------------------------------
module rounded_euclidean_distance #(
  parameter int unsigned COORD_BITS = red_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [COORD_BITS-1:0]          first_x_i,
  input  logic [COORD_BITS-1:0]          first_y_i,
  input  logic [COORD_BITS-1:0]          second_x_i,
  input  logic [COORD_BITS-1:0]          second_y_i,
  output logic                           done_o,
  output logic [red_pkg::DIST_BITS-1:0]  distance_o
);
  import red_pkg::*;

  localparam int unsigned RootBits = COORD_BITS + 1;
  localparam int unsigned RadBits  = 2 * RootBits;

  logic                  sum_valid;
  logic [2*COORD_BITS:0] sum;
  logic                  valid_c [RootBits+1];
  logic [RadBits-1:0]    rad_c   [RootBits+1];
  logic [RootBits-1:0]   root_c  [RootBits+1];
  logic [RootBits:0]     rem_c   [RootBits+1];

  // The pipeline never stalls
  assign busy_o = 1'b0;

  // Differences, squares and sum of squares
  red_diff_sq #(
    .COORD_BITS (COORD_BITS)
  ) u_diff_sq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .valid_o    (sum_valid),
    .sum_o      (sum)
  );

  // Seed the root chain
  assign valid_c[0] = sum_valid;
  assign rad_c[0]   = {1'b0, sum};
  assign root_c[0]  = '0;
  assign rem_c[0]   = '0;

  // One cell per root bit, most significant first
  for (genvar k = 0; k < RootBits; k++) begin : g_cell
    red_root_cell #(
      .ROOT_BITS (RootBits),
      .STEP      (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .rad_i   (rad_c[k]),
      .root_i  (root_c[k]),
      .rem_i   (rem_c[k]),
      .valid_o (valid_c[k+1]),
      .rad_o   (rad_c[k+1]),
      .root_o  (root_c[k+1]),
      .rem_o   (rem_c[k+1])
    );
  end

  // Round to nearest and register the result
  red_round #(
    .ROOT_BITS (RootBits)
  ) u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_c[RootBits]),
    .root_i     (root_c[RootBits]),
    .rem_i      (rem_c[RootBits]),
    .done_o     (done_o),
    .distance_o (distance_o)
  );

endmodule

// ===== rtl/red_diff_sq.sv =====
// ----------------------------------------------------------------------------
// red_diff_sq
// Front end: absolute coordinate differences, squares and their sum,
// one register stage each.
// ----------------------------------------------------------------------------
`include "rounded_euclidean_distance_macros.svh"

module red_diff_sq #(
  parameter int unsigned COORD_BITS = red_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [COORD_BITS-1:0]   first_x_i,
  input  logic [COORD_BITS-1:0]   first_y_i,
  input  logic [COORD_BITS-1:0]   second_x_i,
  input  logic [COORD_BITS-1:0]   second_y_i,
  output logic                    valid_o,
  output logic [2*COORD_BITS:0]   sum_o
);
  import red_pkg::*;

  localparam int unsigned SqBits  = 2 * COORD_BITS;
  localparam int unsigned SumBits = SqBits + 1;

  logic                  v1_q, v2_q, v3_q;
  logic [COORD_BITS-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [SqBits-1:0]     sqx_q, sqy_q;
  logic [SumBits-1:0]    sum_q;

  // Form absolute differences
  always_comb begin
    dx_d = (first_x_i >= second_x_i) ? (first_x_i - second_x_i) : (second_x_i - first_x_i);
    dy_d = (first_y_i >= second_y_i) ? (first_y_i - second_y_i) : (second_y_i - first_y_i);
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Hold differences, squares and sum
  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sqx_q <= SqBits'(dx_q) * SqBits'(dx_q);
    sqy_q <= SqBits'(dy_q) * SqBits'(dy_q);
    sum_q <= SumBits'(sqx_q) + SumBits'(sqy_q);
  end

  assign valid_o = v3_q;
  assign sum_o   = sum_q;

  // A square is 0 or 1 modulo 4, and keeps the parity of its root
  `RED_ASSERT_IMPL(a_sq_mod4, clk_i, rst_ni, v2_q, (sqx_q[1] == 1'b0) && (sqy_q[1] == 1'b0))
  `RED_ASSERT_IMPL(a_sq_parity, clk_i, rst_ni, v2_q, (sqx_q[0] == $past(dx_q[0])) && (sqy_q[0] == $past(dy_q[0])))

endmodule

// ===== rtl/red_root_cell.sv =====
// ----------------------------------------------------------------------------
// red_root_cell
// One digit step of the restoring square root: takes the next bit pair of
// the radicand, settles one root bit and hands on to the next cell.
// ----------------------------------------------------------------------------
`include "rounded_euclidean_distance_macros.svh"

module red_root_cell #(
  parameter int unsigned ROOT_BITS = red_pkg::COORD_BITS_DEF + 1,
  parameter int unsigned STEP      = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [2*ROOT_BITS-1:0]   rad_i,
  input  logic [ROOT_BITS-1:0]     root_i,
  input  logic [ROOT_BITS:0]       rem_i,
  output logic                     valid_o,
  output logic [2*ROOT_BITS-1:0]   rad_o,
  output logic [ROOT_BITS-1:0]     root_o,
  output logic [ROOT_BITS:0]       rem_o
);
  import red_pkg::*;

  localparam int unsigned RadBits = 2 * ROOT_BITS;
  localparam int unsigned WorkBits = ROOT_BITS + 2;

  logic                 valid_q;
  logic [RadBits-1:0]   rad_d, rad_q;
  logic [ROOT_BITS-1:0] root_d, root_q;
  logic [ROOT_BITS:0]   rem_d, rem_q;
  logic [WorkBits-1:0]  rem_sh, trial, diff;
  logic                 fit;

  // Bring down the next bit pair and try the root bit
  always_comb begin
    rem_sh = {rem_i[ROOT_BITS-1:0], rad_i[RadBits-1 -: 2]};
    trial  = {root_i, 2'b01};
    fit    = (rem_sh >= trial);
    diff   = rem_sh - trial;
    rem_d  = fit ? diff[ROOT_BITS:0] : rem_sh[ROOT_BITS:0];
    root_d = {root_i[ROOT_BITS-2:0], fit};
    rad_d  = {rad_i[RadBits-3:0], 2'b00};
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold the partial root state
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign root_o  = root_q;
  assign rem_o   = rem_q;

  // Remainder never exceeds twice the partial root
  `RED_ASSERT_ALWAYS(a_rem_bound, clk_i, rst_ni, !valid_q || ({1'b0, rem_q} <= {1'b0, root_q, 1'b0}))
  // After this step the partial root has at most STEP+1 bits
  `RED_ASSERT_IMPL(a_root_width, clk_i, rst_ni, valid_q, (root_q >> (STEP + 1)) == '0)

endmodule

// ===== rtl/red_round.sv =====
// ----------------------------------------------------------------------------
// red_round
// Final stage: rounds the floor root up when the remainder exceeds it.
// ----------------------------------------------------------------------------
module red_round #(
  parameter int unsigned ROOT_BITS = red_pkg::COORD_BITS_DEF + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [ROOT_BITS-1:0]           root_i,
  input  logic [ROOT_BITS:0]             rem_i,
  output logic                           done_o,
  output logic [red_pkg::DIST_BITS-1:0]  distance_o
);
  import red_pkg::*;

  localparam int unsigned RndBits = (ROOT_BITS + 1 > DIST_BITS) ? ROOT_BITS + 1 : DIST_BITS;

  logic                 done_q;
  logic [RndBits-1:0]   rnd;
  logic [DIST_BITS-1:0] dist_q;

  // Round up when s - f*f > f
  always_comb begin
    rnd = RndBits'(root_i) + RndBits'(rem_i > {1'b0, root_i});
  end

  // Advance the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  // Hold the result
  always_ff @(posedge clk_i) begin
    dist_q <= rnd[DIST_BITS-1:0];
  end

  assign done_o     = done_q;
  assign distance_o = dist_q;

endmodule
